// ===== sv/positional_circular_list_defines.svh =====
// Assertion macros for the list RTL.
`ifndef POSITIONAL_CIRCULAR_LIST_DEFINES_SVH
`define POSITIONAL_CIRCULAR_LIST_DEFINES_SVH

`ifndef SYNTHESIS

// Check post in the same cycle that pre holds.
`define PCL_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check post in the cycle after pre holds.
`define PCL_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define PCL_ASSERT_NOW(label, pre, post, msg)
`define PCL_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// ===== sv/pcl_pkg.sv =====
package pcl_pkg;

    localparam int FuncWidth  = 3;
    localparam int OutWidth   = 32;
    localparam int PosWidth   = 5;
    localparam int CountWidth = 5;

    typedef enum logic [FuncWidth-1:0] {
        FN_INS_FIRST = 3'd0,
        FN_INS_LAST  = 3'd1,
        FN_INS_AT    = 3'd2,
        FN_DEL_FIRST = 3'd3,
        FN_DEL_LAST  = 3'd4,
        FN_DEL_AT    = 3'd5,
        FN_DISPLAY   = 3'd6,
        FN_COUNT     = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_NOP = 2'd0,
        OP_INS = 2'd1,
        OP_DEL = 2'd2,
        OP_ROT = 2'd3
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    disp_start;
        logic    load;
        logic    elem;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic ins_pos_ok;
        logic del_pos_ok;
        logic disp_last;
    } t_dp_stat;

endpackage

// ===== sv/pcl_datapath.sv =====
module pcl_datapath #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [pcl_pkg::FuncWidth-1:0]         i_func,
    input  logic signed [pcl_pkg::OutWidth-1:0]   i_value,
    input  logic [pcl_pkg::PosWidth-1:0]          i_position,
    input  pcl_pkg::t_dp_cmd                      i_cmd,
    output pcl_pkg::t_dp_stat                     o_stat,
    output logic signed [pcl_pkg::OutWidth-1:0]   o_data,
    output logic                                  o_is_element,
    output logic                                  o_last,
    output logic [pcl_pkg::CountWidth-1:0]        o_count,
    output logic [1:0]                            o_status
);

    localparam int SW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = ((SW > pcl_pkg::PosWidth) ? SW : pcl_pkg::PosWidth) + 1;
    localparam int OW   = pcl_pkg::OutWidth;
    localparam int CntW = pcl_pkg::CountWidth;

    logic [DATA_WIDTH-1:0] r_cell [CAPACITY];
    logic [SW-1:0]         r_size;
    logic [SW-1:0]         n_size;
    logic [IW-1:0]         r_disp_idx;

    logic signed [OW-1:0]  r_res_data;
    logic                  r_res_elem;
    logic                  r_res_last;
    logic [CntW-1:0]       r_res_count;
    logic [1:0]            r_res_status;

    logic [CW-1:0]         size_w;
    logic [CW-1:0]         pos_w;
    logic [CW-1:0]         idx_w;
    logic                  disp_last;
    logic [DATA_WIDTH-1:0] val_st;
    logic [OW-1:0]         head_out;

    assign size_w = CW'(r_size);
    assign pos_w  = CW'(i_position);

    // Target index of the shift for insert and delete.
    always_comb begin
        unique case (pcl_pkg::t_func'(i_func)) inside
            pcl_pkg::FN_INS_FIRST, pcl_pkg::FN_DEL_FIRST: idx_w = '0;
            pcl_pkg::FN_INS_LAST:                         idx_w = size_w;
            pcl_pkg::FN_DEL_LAST:                         idx_w = size_w - CW'(1);
            pcl_pkg::FN_INS_AT, pcl_pkg::FN_DEL_AT:       idx_w = pos_w - CW'(1);
            default:                                      idx_w = '0;
        endcase
    end

    assign disp_last = (CW'(r_disp_idx) + CW'(1)) == size_w;

    assign o_stat.full       = size_w == CW'(CAPACITY);
    assign o_stat.empty      = r_size == '0;
    assign o_stat.ins_pos_ok = (pos_w != '0) && (pos_w <= size_w + CW'(1));
    assign o_stat.del_pos_ok = (pos_w != '0) && (pos_w <= size_w);
    assign o_stat.disp_last  = disp_last;

    generate
        if (DATA_WIDTH <= OW) begin : g_narrow
            assign val_st = i_value[DATA_WIDTH-1:0];
        end else begin : g_wide
            assign val_st = {{(DATA_WIDTH-OW){i_value[OW-1]}}, i_value};
        end
        if (DATA_WIDTH >= OW) begin : g_head_trunc
            assign head_out = r_cell[0][OW-1:0];
        end else begin : g_head_ext
            assign head_out = {{(OW-DATA_WIDTH){r_cell[0][DATA_WIDTH-1]}}, r_cell[0]};
        end
    endgenerate

    // Affected cells shift in parallel; rotate brings the head around behind the tail.
    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            localparam int Prev = (g == 0) ? 0 : g - 1;
            localparam int Next = (g == CAPACITY - 1) ? g : g + 1;
            always_ff @(posedge i_clk) begin
                unique case (i_cmd.op)
                    pcl_pkg::OP_INS: begin
                        if (CW'(g) > idx_w) begin
                            r_cell[g] <= r_cell[Prev];
                        end else if (CW'(g) == idx_w) begin
                            r_cell[g] <= val_st;
                        end
                    end
                    pcl_pkg::OP_DEL: begin
                        if ((CW'(g) >= idx_w) && (g < CAPACITY - 1)) begin
                            r_cell[g] <= r_cell[Next];
                        end
                    end
                    pcl_pkg::OP_ROT: begin
                        if (CW'(g) + CW'(1) < size_w) begin
                            r_cell[g] <= r_cell[Next];
                        end else if (CW'(g) + CW'(1) == size_w) begin
                            r_cell[g] <= r_cell[0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    endgenerate

    always_comb begin
        unique case (i_cmd.op)
            pcl_pkg::OP_INS: n_size = r_size + SW'(1);
            pcl_pkg::OP_DEL: n_size = r_size - SW'(1);
            default:         n_size = r_size;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= '0;
            r_disp_idx <= '0;
        end else begin
            r_size <= n_size;
            if (i_cmd.disp_start) begin
                r_disp_idx <= '0;
            end else if (i_cmd.op == pcl_pkg::OP_ROT) begin
                r_disp_idx <= r_disp_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_data   <= i_cmd.elem ? head_out : '0;
            r_res_elem   <= i_cmd.elem;
            r_res_last   <= !i_cmd.elem || disp_last;
            r_res_count  <= CntW'(n_size);
            r_res_status <= i_cmd.status;
        end
    end

    assign o_data       = r_res_data;
    assign o_is_element = r_res_elem;
    assign o_last       = r_res_last;
    assign o_count      = r_res_count;
    assign o_status     = r_res_status;

endmodule

// ===== sv/pcl_ctrl.sv =====
module pcl_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_stall,
    input  logic [pcl_pkg::FuncWidth-1:0] i_func,
    input  pcl_pkg::t_dp_stat             i_stat,
    output logic                          o_stall,
    output logic                          o_valid,
    output pcl_pkg::t_dp_cmd              o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DISP = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && out_free);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state           = r_state;
        o_cmd.op          = pcl_pkg::OP_NOP;
        o_cmd.disp_start  = 1'b0;
        o_cmd.load        = 1'b0;
        o_cmd.elem        = 1'b0;
        o_cmd.status      = pcl_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && out_free) begin
                    o_cmd.load = 1'b1;
                    unique case (pcl_pkg::t_func'(i_func)) inside
                        pcl_pkg::FN_INS_FIRST, pcl_pkg::FN_INS_LAST, pcl_pkg::FN_INS_AT: begin
                            if (i_stat.full) begin
                                o_cmd.status = pcl_pkg::ST_FULL;
                            end else if ((pcl_pkg::t_func'(i_func) == pcl_pkg::FN_INS_AT)
                                         && !i_stat.ins_pos_ok) begin
                                o_cmd.status = pcl_pkg::ST_BADPOS;
                            end else begin
                                o_cmd.op = pcl_pkg::OP_INS;
                            end
                        end
                        pcl_pkg::FN_DEL_FIRST, pcl_pkg::FN_DEL_LAST, pcl_pkg::FN_DEL_AT: begin
                            if (i_stat.empty) begin
                                o_cmd.status = pcl_pkg::ST_EMPTY;
                            end else if ((pcl_pkg::t_func'(i_func) == pcl_pkg::FN_DEL_AT)
                                         && !i_stat.del_pos_ok) begin
                                o_cmd.status = pcl_pkg::ST_BADPOS;
                            end else begin
                                o_cmd.op = pcl_pkg::OP_DEL;
                            end
                        end
                        pcl_pkg::FN_DISPLAY: begin
                            if (i_stat.empty) begin
                                o_cmd.status = pcl_pkg::ST_EMPTY;
                            end else begin
                                // hold the result slot; elements follow from S_DISP
                                o_cmd.load       = 1'b0;
                                o_cmd.disp_start = 1'b1;
                                n_state          = S_DISP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DISP: begin
                if (out_free) begin
                    o_cmd.op   = pcl_pkg::OP_ROT;
                    o_cmd.load = 1'b1;
                    o_cmd.elem = 1'b1;
                    if (i_stat.disp_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/positional_circular_list.sv =====
// A non-display transaction's result is registered and shows in the cycle after acceptance.
// Throughput: one non-display transaction per cycle while results are taken.
// Display: S_DISP rotates the ring and registers one element per cycle while results are
// taken; the input stalls while the element ring rotates once.
// Reset: synchronous active low; clears the count and output valid, not the elements.
`include "positional_circular_list_defines.svh"

module positional_circular_list #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [pcl_pkg::FuncWidth-1:0]       i_func,
    input  logic signed [pcl_pkg::OutWidth-1:0] i_value,
    input  logic [pcl_pkg::PosWidth-1:0]        i_position,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [pcl_pkg::OutWidth-1:0] o_data,
    output logic                                o_is_element,
    output logic                                o_last,
    output logic [pcl_pkg::CountWidth-1:0]      o_count,
    output logic [1:0]                          o_status
);

    pcl_pkg::t_dp_cmd  dp_cmd;
    pcl_pkg::t_dp_stat dp_stat;

    pcl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_func  (i_func),
        .i_stat  (dp_stat),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (dp_cmd)
    );

    pcl_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_position   (i_position),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .o_data       (o_data),
        .o_is_element (o_is_element),
        .o_last       (o_last),
        .o_count      (o_count),
        .o_status     (o_status)
    );

    `PCL_ASSERT_NOW(a_elem_ok, o_valid && o_is_element, o_status == pcl_pkg::ST_OK,
                    "element with bad status")
    `PCL_ASSERT_NOW(a_elem_count, o_valid && o_is_element, o_count != '0,
                    "element from empty list")
    `PCL_ASSERT_NOW(a_nonlast_elem, o_valid && !o_last, o_is_element,
                    "non-final result without element")
    `PCL_ASSERT_NEXT(a_count_result,
                     i_valid && !o_stall && (i_func == pcl_pkg::FN_COUNT),
                     o_valid && o_last && !o_is_element, "count transaction gave no result")

endmodule

// ===== verif/pcl_list_checker.sv =====
module pcl_list_checker #(
    parameter int Depth = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [pcl_pkg::FuncWidth-1:0]       i_func,
    input  logic signed [pcl_pkg::OutWidth-1:0] i_value,
    input  logic [pcl_pkg::PosWidth-1:0]        i_position,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [pcl_pkg::OutWidth-1:0] i_data,
    input  logic                                i_is_element,
    input  logic                                i_last,
    input  logic [pcl_pkg::CountWidth-1:0]      i_count,
    input  logic [1:0]                          i_status,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_ops,
    output int                                  o_results,
    output int                                  o_full_hits,
    output int                                  o_empty_hits,
    output int                                  o_badpos_hits
);

    typedef struct packed {
        logic signed [pcl_pkg::OutWidth-1:0] data;
        logic                                is_element;
        logic                                last;
        logic [pcl_pkg::CountWidth-1:0]      count;
        pcl_pkg::t_status                    status;
    } t_list_result;

    logic signed [pcl_pkg::OutWidth-1:0] list_vals [Depth];
    int                                  list_len;
    t_list_result                        expected_results [$];

    initial begin
        list_len      = 0;
        o_errors      = 0;
        o_pending     = 0;
        o_ops         = 0;
        o_results     = 0;
        o_full_hits   = 0;
        o_empty_hits  = 0;
        o_badpos_hits = 0;
    end

    task automatic report_error(input string msg);
        $display("[%0t] list check: %s", $time, msg);
        o_errors++;
    endtask

    task automatic push_result(input logic signed [31:0] data, input logic is_element,
                               input logic last, input pcl_pkg::t_status status);
        t_list_result r;
        r.data       = data;
        r.is_element = is_element;
        r.last       = last;
        r.count      = 5'(list_len);
        r.status     = status;
        expected_results.push_back(r);
    endtask

    // Apply one operation to the shadow list and queue the results it produces.
    task automatic apply_list_op(input pcl_pkg::t_func fn, input logic signed [31:0] val,
                                 input logic [pcl_pkg::PosWidth-1:0] pos);
        pcl_pkg::t_status st;
        int               idx;
        st  = pcl_pkg::ST_OK;
        idx = -1;
        case (fn)
            pcl_pkg::FN_INS_FIRST, pcl_pkg::FN_INS_LAST, pcl_pkg::FN_INS_AT: begin
                if (list_len >= Depth) begin
                    st = pcl_pkg::ST_FULL;
                end else if (fn == pcl_pkg::FN_INS_FIRST) begin
                    idx = 0;
                end else if (fn == pcl_pkg::FN_INS_LAST) begin
                    idx = list_len;
                end else if (pos < 1 || pos > list_len + 1) begin
                    st = pcl_pkg::ST_BADPOS;
                end else begin
                    idx = pos - 1;
                end
                if (idx >= 0) begin
                    for (int k = list_len; k > idx; k--) begin
                        list_vals[k] = list_vals[k-1];
                    end
                    list_vals[idx] = val;
                    list_len++;
                end
            end
            pcl_pkg::FN_DEL_FIRST, pcl_pkg::FN_DEL_LAST, pcl_pkg::FN_DEL_AT: begin
                if (list_len == 0) begin
                    st = pcl_pkg::ST_EMPTY;
                end else if (fn == pcl_pkg::FN_DEL_FIRST) begin
                    idx = 0;
                end else if (fn == pcl_pkg::FN_DEL_LAST) begin
                    idx = list_len - 1;
                end else if (pos < 1 || pos > list_len) begin
                    st = pcl_pkg::ST_BADPOS;
                end else begin
                    idx = pos - 1;
                end
                if (idx >= 0) begin
                    for (int k = idx; k < list_len - 1; k++) begin
                        list_vals[k] = list_vals[k+1];
                    end
                    list_len--;
                end
            end
            default: begin
            end
        endcase

        if (fn == pcl_pkg::FN_DISPLAY && list_len != 0) begin
            for (int k = 0; k < list_len; k++) begin
                push_result(list_vals[k], 1'b1, k == list_len - 1, pcl_pkg::ST_OK);
            end
        end else if (fn == pcl_pkg::FN_DISPLAY) begin
            push_result('0, 1'b0, 1'b1, pcl_pkg::ST_EMPTY);
        end else begin
            push_result('0, 1'b0, 1'b1, st);
        end

        case (st)
            pcl_pkg::ST_FULL:   o_full_hits++;
            pcl_pkg::ST_EMPTY:  o_empty_hits++;
            pcl_pkg::ST_BADPOS: o_badpos_hits++;
            default: begin
            end
        endcase
        if (fn == pcl_pkg::FN_DISPLAY && list_len == 0) begin
            o_empty_hits++;
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n) begin
            // Results at this edge belong to older transactions: check before predicting.
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (expected_results.size() == 0) begin
                    report_error($sformatf("unexpected result data=%0d count=%0d status=%0d",
                                           i_data, i_count, i_status));
                end else begin
                    want = expected_results.pop_front();
                    if (i_data !== want.data) begin
                        report_error($sformatf("data got %0d want %0d", i_data, want.data));
                    end
                    if (i_is_element !== want.is_element) begin
                        report_error($sformatf("is_element got %0b want %0b",
                                               i_is_element, want.is_element));
                    end
                    if (i_last !== want.last) begin
                        report_error($sformatf("last got %0b want %0b", i_last, want.last));
                    end
                    if (i_count !== want.count) begin
                        report_error($sformatf("count got %0d want %0d", i_count, want.count));
                    end
                    if (i_status !== want.status) begin
                        report_error($sformatf("status got %0d want %0d",
                                               i_status, want.status));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                o_ops++;
                apply_list_op(pcl_pkg::t_func'(i_func), i_value, i_position);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

    localparam int TimeoutCycles = 200000;
    localparam int ClkHalf       = 6;

    typedef enum {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } t_mix;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic [pcl_pkg::FuncWidth-1:0]       i_func;
    logic signed [pcl_pkg::OutWidth-1:0] i_value;
    logic [pcl_pkg::PosWidth-1:0]        i_position;
    logic                                o_valid;
    logic                                i_stall;
    logic signed [pcl_pkg::OutWidth-1:0] o_data;
    logic                                o_is_element;
    logic                                o_last;
    logic [pcl_pkg::CountWidth-1:0]      o_count;
    logic [1:0]                          o_status;

    logic quiet;
    int   errors;
    int   pending;
    int   ops;
    int   results;
    int   full_hits;
    int   empty_hits;
    int   badpos_hits;

    positional_circular_list u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data),
        .o_is_element (o_is_element),
        .o_last       (o_last),
        .o_count      (o_count),
        .o_status     (o_status)
    );

    pcl_list_checker u_list_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_func        (i_func),
        .i_value       (i_value),
        .i_position    (i_position),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_data        (o_data),
        .i_is_element  (o_is_element),
        .i_last        (o_last),
        .i_count       (o_count),
        .i_status      (o_status),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_ops         (ops),
        .o_results     (results),
        .o_full_hits   (full_hits),
        .o_empty_hits  (empty_hits),
        .o_badpos_hits (badpos_hits)
    );

    always begin
        i_clk = 1'b0;
        #ClkHalf;
        i_clk = 1'b1;
        #ClkHalf;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_func     = '0;
        i_value    = '0;
        i_position = '0;
        i_stall    = 1'b0;
        quiet      = 1'b0;
    end

    // Back-pressure on the result side.
    always @(negedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(0, 99) < 24);
    end

    // Call at a falling edge; returns at the falling edge after the transaction is taken.
    task automatic send_op(input pcl_pkg::t_func fn, input logic signed [31:0] val,
                           input logic [pcl_pkg::PosWidth-1:0] pos);
        while (!quiet && $urandom_range(0, 99) < 24) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= fn;
        i_value    <= val;
        i_position <= pos;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic run_phase(input t_mix mix, input int n);
        pcl_pkg::t_func            fn;
        logic signed [31:0]        val;
        logic [pcl_pkg::PosWidth-1:0] pos;
        int                        r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            case (mix)
                MIX_GROW: begin
                    fn = r < 25 ? pcl_pkg::FN_INS_FIRST :
                         r < 45 ? pcl_pkg::FN_INS_LAST  :
                         r < 70 ? pcl_pkg::FN_INS_AT    :
                         r < 75 ? pcl_pkg::FN_DEL_FIRST :
                         r < 80 ? pcl_pkg::FN_DEL_LAST  :
                         r < 85 ? pcl_pkg::FN_DEL_AT    :
                         r < 93 ? pcl_pkg::FN_DISPLAY   : pcl_pkg::FN_COUNT;
                end
                MIX_SHRINK: begin
                    fn = r < 5  ? pcl_pkg::FN_INS_FIRST :
                         r < 10 ? pcl_pkg::FN_INS_LAST  :
                         r < 15 ? pcl_pkg::FN_INS_AT    :
                         r < 35 ? pcl_pkg::FN_DEL_FIRST :
                         r < 55 ? pcl_pkg::FN_DEL_LAST  :
                         r < 80 ? pcl_pkg::FN_DEL_AT    :
                         r < 90 ? pcl_pkg::FN_DISPLAY   : pcl_pkg::FN_COUNT;
                end
                default: begin
                    fn = pcl_pkg::t_func'($urandom_range(0, 7));
                end
            endcase
            case ($urandom_range(0, 19))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7fff_ffff;
                2:       val = -32'sd1;
                3:       val = '0;
                default: val = $urandom;
            endcase
            pos = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 17));
            send_op(fn, val, pos);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: every delete reports empty, even with a bad position.
        send_op(pcl_pkg::FN_DISPLAY,   '0, 5'd0);
        send_op(pcl_pkg::FN_COUNT,     -32'sd1, 5'd31);
        send_op(pcl_pkg::FN_DEL_FIRST, '0, 5'd0);
        send_op(pcl_pkg::FN_DEL_LAST,  '0, 5'd0);
        send_op(pcl_pkg::FN_DEL_AT,    '0, 5'd0);
        send_op(pcl_pkg::FN_INS_AT,    32'sd5, 5'd0);
        send_op(pcl_pkg::FN_INS_AT,    32'sd5, 5'd2);
        send_op(pcl_pkg::FN_INS_AT,    32'sh8000_0000, 5'd1);
        send_op(pcl_pkg::FN_INS_FIRST, 32'sh7fff_ffff, 5'd0);
        send_op(pcl_pkg::FN_INS_LAST,  -32'sd1, 5'd0);
        send_op(pcl_pkg::FN_INS_AT,    32'sh5555_5555, 5'd4);
        send_op(pcl_pkg::FN_INS_AT,    32'shaaaa_aaaa, 5'd2);
        send_op(pcl_pkg::FN_DISPLAY,   '0, 5'd0);
        send_op(pcl_pkg::FN_INS_AT,    32'sd1, 5'd31);
        send_op(pcl_pkg::FN_DEL_AT,    '0, 5'd0);
        send_op(pcl_pkg::FN_DEL_AT,    '0, 5'd6);
        send_op(pcl_pkg::FN_DEL_AT,    '0, 5'd5);
        send_op(pcl_pkg::FN_DEL_AT,    '0, 5'd2);
        send_op(pcl_pkg::FN_DEL_FIRST, '0, 5'd0);
        send_op(pcl_pkg::FN_DEL_LAST,  '0, 5'd0);
        send_op(pcl_pkg::FN_COUNT,     '0, 5'd0);
        send_op(pcl_pkg::FN_DISPLAY,   '0, 5'd0);

        run_phase(MIX_GROW, 60);
        // Probe the full list with each insert, with good and bad positions.
        send_op(pcl_pkg::FN_INS_FIRST, 32'sd7, 5'd0);
        send_op(pcl_pkg::FN_INS_LAST,  32'sd7, 5'd0);
        send_op(pcl_pkg::FN_INS_AT,    32'sd7, 5'd17);
        send_op(pcl_pkg::FN_INS_AT,    32'sd7, 5'd0);
        send_op(pcl_pkg::FN_DISPLAY,   '0, 5'd0);
        quiet <= 1'b1;
        run_phase(MIX_SHRINK, 30);
        quiet <= 1'b0;
        run_phase(MIX_SHRINK, 10);
        run_phase(MIX_EVEN, 45);
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("list run: %0d operations in, %0d results out", ops, results);
        $display("list run: refusals - full %0d, empty %0d, bad position %0d",
                 full_hits, empty_hits, badpos_hits);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(TimeoutCycles * 2 * ClkHalf);
        $display("FAILURE");
        $finish;
    end

endmodule
